>>> rtl/core/vft_pkg.sv
// ----------------------------------------------------------------------------
// vft_pkg
// Shared types and constants of the value frequency table.
// ----------------------------------------------------------------------------
`default_nettype none

package vft_pkg;

   // item modes
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_QUERY  = 1'b1;

   // result and value field widths
   localparam int RSP_COUNT_WIDTH    = 16;
   localparam int RSP_DISTINCT_WIDTH = 7;
   localparam int VALUE_WIDTH        = 32;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // table access controls from the sequencer
   typedef struct packed {
      logic rd_en;
      logic wr_value_en;
      logic wr_count_en;
   } tbl_ctl_type;

endpackage

`default_nettype wire

>>> rtl/core/vft_table.sv
// ----------------------------------------------------------------------------
// vft_table
// Value and count memories: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module vft_table #(
   parameter int DEPTH       = 64,
   parameter int COUNT_WIDTH = 16,
   parameter int AW          = 6
) (
   input  wire logic                          clock,
   input  wire vft_pkg::tbl_ctl_type          ctl,
   input  wire logic [AW-1:0]                 rd_addr,
   input  wire logic [AW-1:0]                 wr_addr,
   input  wire logic [vft_pkg::VALUE_WIDTH-1:0] wr_value,
   input  wire logic [COUNT_WIDTH-1:0]        wr_count,
   output logic [vft_pkg::VALUE_WIDTH-1:0]    rd_value,
   output logic [COUNT_WIDTH-1:0]             rd_count
);

   logic [vft_pkg::VALUE_WIDTH-1:0] value_mem [DEPTH];
   logic [COUNT_WIDTH-1:0]          count_mem [DEPTH];

   // value memory
   always_ff @(posedge clock) begin
      if (ctl.wr_value_en) begin
         value_mem[wr_addr] <= wr_value;
      end
      if (ctl.rd_en) begin
         rd_value <= value_mem[rd_addr];
      end
   end

   // count memory
   always_ff @(posedge clock) begin
      if (ctl.wr_count_en) begin
         count_mem[wr_addr] <= wr_count;
      end
      if (ctl.rd_en) begin
         rd_count <= count_mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/value_frequency_table.sv
// Items are taken one at a time: no new item is accepted until the last one's
// result has been loaded into the output register. The scan of the value memory
// reads one entry per cycle and stops at a hit or after the last stored entry.
// A finished result waits in the output register while the next item is taken.
// Reset clears the entry count and the control state; the memories are not
// cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// value_frequency_table
// Table of distinct 32-bit values with saturating occurrence counts.
// ----------------------------------------------------------------------------
`default_nettype none

module value_frequency_table #(
   parameter int DEPTH       = 64,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_ready,
   input  wire logic                                     req_mode,
   input  wire logic signed [vft_pkg::VALUE_WIDTH-1:0]   req_value,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_ready,
   output logic [vft_pkg::RSP_COUNT_WIDTH-1:0]           rsp_count,
   output logic                                          rsp_found,
   output logic                                          rsp_dropped,
   output logic [vft_pkg::RSP_DISTINCT_WIDTH-1:0]        rsp_distinct_entries
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int UW = $clog2(DEPTH + 1);
   localparam logic [UW-1:0] DEPTH_U = UW'(DEPTH);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   vft_pkg::state_type state_ff, state_in;
   vft_pkg::tbl_ctl_type tbl_ctl;

   logic                            mode_ff;
   logic [vft_pkg::VALUE_WIDTH-1:0] value_ff;
   logic [UW-1:0]                   idx_ff, idx_in;
   logic                            pend_ff, pend_in;
   logic [AW-1:0]                   pend_idx_ff;
   logic                            hit_ff, hit_in;
   logic [AW-1:0]                   slot_ff, slot_in;
   logic [COUNT_WIDTH-1:0]          cnt_ff, cnt_in;
   logic [UW-1:0]                   used_ff, used_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [vft_pkg::RSP_COUNT_WIDTH-1:0]    rsp_count_ff, rsp_count_in;
   logic                                   rsp_found_ff, rsp_found_in;
   logic                                   rsp_dropped_ff, rsp_dropped_in;
   logic [vft_pkg::RSP_DISTINCT_WIDTH-1:0] rsp_distinct_ff, rsp_distinct_in;

   logic [vft_pkg::VALUE_WIDTH-1:0] rd_value;
   logic [COUNT_WIDTH-1:0]          rd_count;
   logic [AW-1:0]                   wr_addr;
   logic [COUNT_WIDTH-1:0]          wr_count;

   logic scan_more;
   logic scan_hit;
   logic out_free;
   logic table_full;
   logic [COUNT_WIDTH-1:0] cnt_inc;

   assign scan_more  = (idx_ff < used_ff);
   assign scan_hit   = pend_ff && (rd_value == value_ff);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign table_full = (used_ff >= DEPTH_U);
   assign cnt_inc    = (cnt_ff == COUNT_MAX) ? cnt_ff : (cnt_ff + COUNT_WIDTH'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vft_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = vft_pkg::ST_SCAN;
            end
         end
         vft_pkg::ST_SCAN: begin
            if (scan_hit || (!pend_ff && !scan_more)) begin
               state_in = vft_pkg::ST_DONE;
            end
         end
         vft_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = vft_pkg::ST_IDLE;
            end
         end
         default: state_in = vft_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready            = 1'b0;
      tbl_ctl.rd_en        = 1'b0;
      tbl_ctl.wr_value_en  = 1'b0;
      tbl_ctl.wr_count_en  = 1'b0;
      wr_addr              = used_ff[AW-1:0];
      wr_count             = COUNT_WIDTH'(1);
      unique case (state_ff)
         vft_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         vft_pkg::ST_SCAN: begin
            tbl_ctl.rd_en = scan_more;
         end
         vft_pkg::ST_DONE: begin
            if (out_free && (mode_ff == vft_pkg::MODE_INSERT)) begin
               if (hit_ff) begin
                  tbl_ctl.wr_count_en = 1'b1;
                  wr_addr             = slot_ff;
                  wr_count            = cnt_inc;
               end else if (!table_full) begin
                  tbl_ctl.wr_value_en = 1'b1;
                  tbl_ctl.wr_count_en = 1'b1;
               end
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // scan bookkeeping and result assembly
   always_comb begin
      idx_in          = idx_ff;
      pend_in         = 1'b0;
      hit_in          = hit_ff;
      slot_in         = slot_ff;
      cnt_in          = cnt_ff;
      used_in         = used_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_count_in    = rsp_count_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_dropped_in  = rsp_dropped_ff;
      rsp_distinct_in = rsp_distinct_ff;
      unique case (state_ff)
         vft_pkg::ST_IDLE: begin
            idx_in = '0;
            hit_in = 1'b0;
         end
         vft_pkg::ST_SCAN: begin
            pend_in = scan_more;
            if (scan_more) begin
               idx_in = idx_ff + UW'(1);
            end
            if (scan_hit) begin
               hit_in  = 1'b1;
               slot_in = pend_idx_ff;
               cnt_in  = rd_count;
            end
         end
         vft_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_found_in   = hit_ff;
               rsp_dropped_in = 1'b0;
               rsp_count_in   = '0;
               if (mode_ff == vft_pkg::MODE_QUERY) begin
                  if (hit_ff) begin
                     rsp_count_in = vft_pkg::RSP_COUNT_WIDTH'(cnt_ff);
                  end
               end else if (hit_ff) begin
                  rsp_count_in = vft_pkg::RSP_COUNT_WIDTH'(cnt_inc);
               end else if (!table_full) begin
                  rsp_count_in = vft_pkg::RSP_COUNT_WIDTH'(1);
                  used_in      = used_ff + UW'(1);
               end else begin
                  rsp_dropped_in = 1'b1;
               end
               rsp_distinct_in = vft_pkg::RSP_DISTINCT_WIDTH'(used_in);
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vft_pkg::ST_IDLE;
         used_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff  <= req_mode;
         value_ff <= req_value;
      end
      idx_ff          <= idx_in;
      pend_idx_ff     <= idx_ff[AW-1:0];
      hit_ff          <= hit_in;
      slot_ff         <= slot_in;
      cnt_ff          <= cnt_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_dropped_ff  <= rsp_dropped_in;
      rsp_distinct_ff <= rsp_distinct_in;
   end

   // value and count memories
   vft_table #(
      .DEPTH       (DEPTH),
      .COUNT_WIDTH (COUNT_WIDTH),
      .AW          (AW)
   ) u_table (
      .clock    (clock),
      .ctl      (tbl_ctl),
      .rd_addr  (idx_ff[AW-1:0]),
      .wr_addr  (wr_addr),
      .wr_value (value_ff),
      .wr_count (wr_count),
      .rd_value (rd_value),
      .rd_count (rd_count)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_count            = rsp_count_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_dropped          = rsp_dropped_ff;
   assign rsp_distinct_entries = rsp_distinct_ff;

endmodule

`default_nettype wire
